FILE: hdl/ltkm_pkg.sv
// shared types and constants for the loser-tree merge
package ltkm_pkg;

    localparam logic [63:0] MINUS_INF = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] PLUS_INF  = 64'h7FF0_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_NEXT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_LEAF_RD,
        ST_LEAF_CAP,
        ST_SLOT_RD,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]  stream;
        logic [63:0] value;
        logic        done;
    } res_t;

endpackage

FILE: hdl/ltkm_fcmp.sv
// strict ieee double less-than, the shared compare unit
module ltkm_fcmp (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        lt
);
    logic a_nan;
    logic b_nan;
    logic both_zero;

    always_comb
    begin
        a_nan     = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan     = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan || both_zero)
        begin
            lt = 1'b0;
        end
        else if (a[63] != b[63])
        begin
            lt = a[63];
        end
        else if (!a[63])
        begin
            lt = a[62:0] < b[62:0];
        end
        else
        begin
            lt = a[62:0] > b[62:0];
        end
    end
endmodule

FILE: hdl/ltkm_core.sv
// sequencer, leaf memory and loser slots; each tree level is a slot read then a compare
module ltkm_core #(
    parameter int MAX_STREAMS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  ltkm_pkg::kind_t                      kind,
    input  logic [3:0]                           stream_index,
    input  logic [63:0]                          value_bits,
    input  logic [$clog2(MAX_STREAMS+1)-1:0]     k,
    input  logic                                 res_ready,
    output logic                                 busy,
    output logic                                 res_valid,
    output ltkm_pkg::res_t                       res
);
    import ltkm_pkg::*;

    localparam int IW = $clog2(MAX_STREAMS + 1);
    localparam int NW = $clog2(MAX_STREAMS);

    logic [63:0]   leaf_mem [MAX_STREAMS+1];
    logic [IW-1:0] loser_mem [MAX_STREAMS];

    state_t        state_reg, state_next;
    logic [IW-1:0] cand_reg, cand_next;
    logic [63:0]   cval_reg, cval_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] lidx_reg, lidx_next;
    logic          build_reg, build_next;
    logic [IW-1:0] win_reg, win_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [63:0]   leaf_rd_reg;

    logic          leaf_we;
    logic [IW-1:0] leaf_wa;
    logic [63:0]   leaf_wd;
    logic [IW-1:0] leaf_ra;
    logic          los_we;
    logic [NW-1:0] los_wa;
    logic [IW-1:0] los_wd;
    logic          los0_we;
    logic [IW-1:0] los0_wd;

    logic          lt;
    logic          wins;
    logic [IW-1:0] w_clamp;
    logic [IW:0]   sum_next;
    logic [IW:0]   sum_leaf;

    ltkm_fcmp u_fcmp (
        .a  (leaf_rd_reg),
        .b  (cval_reg),
        .lt (lt)
    );

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        leaf_rd_reg <= leaf_mem[leaf_ra];
        if (los_we)
        begin
            loser_mem[los_wa] <= los_wd;
        end
        if (los0_we)
        begin
            loser_mem[0] <= los0_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        cval_reg <= cval_next;
        node_reg <= node_next;
        lidx_reg <= lidx_next;
        win_reg  <= win_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        cval_next  = cval_reg;
        node_next  = node_reg;
        lidx_next  = lidx_reg;
        build_next = build_reg;
        win_next   = win_reg;
        slot_next  = slot_reg;
        leaf_we    = 1'b0;
        leaf_wa    = '0;
        leaf_wd    = value_bits;
        leaf_ra    = slot_reg;
        los_we     = 1'b0;
        los_wa     = node_reg[NW-1:0];
        los_wd     = cand_reg;
        los0_we    = 1'b0;
        los0_wd    = cand_reg;
        res_valid  = 1'b0;

        w_clamp  = (32'(win_reg) >= MAX_STREAMS) ? IW'(MAX_STREAMS - 1) : win_reg;
        sum_next = {1'b0, w_clamp} + {1'b0, k};
        sum_leaf = {1'b0, lidx_reg} + {1'b0, k};
        wins     = (slot_reg == k) || ((cand_reg != k) && lt);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            if (32'(stream_index) < MAX_STREAMS)
                            begin
                                leaf_we = 1'b1;
                                leaf_wa = IW'(stream_index);
                            end
                        end
                        KIND_BUILD:
                        begin
                            leaf_we    = 1'b1;
                            leaf_wa    = k;
                            leaf_wd    = MINUS_INF;
                            lidx_next  = '0;
                            build_next = 1'b1;
                            state_next = ST_INIT;
                        end
                        KIND_NEXT:
                        begin
                            leaf_we    = 1'b1;
                            leaf_wa    = w_clamp;
                            cand_next  = w_clamp;
                            cval_next  = value_bits;
                            node_next  = sum_next[IW:1];
                            build_next = 1'b0;
                            state_next = ST_SLOT_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                los_we = 1'b1;
                los_wa = lidx_reg[NW-1:0];
                los_wd = k;
                if (lidx_reg == k - IW'(1))
                begin
                    state_next = ST_LEAF_RD;
                end
                else
                begin
                    lidx_next = lidx_reg + IW'(1);
                end
            end
            ST_LEAF_RD:
            begin
                leaf_ra    = lidx_reg;
                state_next = ST_LEAF_CAP;
            end
            ST_LEAF_CAP:
            begin
                cand_next  = lidx_reg;
                cval_next  = leaf_rd_reg;
                node_next  = sum_leaf[IW:1];
                state_next = ST_SLOT_RD;
            end
            ST_SLOT_RD:
            begin
                slot_next  = loser_mem[node_reg[NW-1:0]];
                leaf_ra    = slot_next;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // the slot's leaf beats the travelling leaf: swap them
                if (wins)
                begin
                    los_we    = 1'b1;
                    cand_next = slot_reg;
                    cval_next = leaf_rd_reg;
                end
                node_next = node_reg >> 1;
                if (node_reg == IW'(1))
                begin
                    los0_we  = 1'b1;
                    los0_wd  = cand_next;
                    win_next = cand_next;
                    if (build_reg && (lidx_reg != '0))
                    begin
                        lidx_next  = lidx_reg - IW'(1);
                        state_next = ST_LEAF_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_SLOT_RD;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign res.stream = 4'(cand_reg);
    assign res.value  = cval_reg;
    assign res.done   = (cval_reg == PLUS_INF);

    a_cmp_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (node_reg != '0))
        else $error("tree walk compared at the root slot");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("sequencer left idle without an item");

    a_done_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DONE) |-> $past(state_reg == ST_CMP))
        else $error("result raised without a final compare");
endmodule

FILE: hdl/loser_tree_kway_merge.sv
// top level of the loser-tree k-way merge of sorted ieee double streams
//
//  channel  handshake          word
//  in       in_valid/in_stall  kind, stream_index, value_bits
//  out      out_valid/out_stall winner_stream, winner_value, all_done
//  cfg      cfg_valid/cfg_ready cfg_data (streams_in_use)
//
// a load word writes its leaf while the sequencer stays idle; a next word writes
//   the last winner's leaf, then does a slot read and a compare per tree level up to the root
// a build word first fills loser slots 0..k-1 with index k, then walks the leaves from k-1 down to 0
// rst_n clears control and sets streams_in_use to 16 (clamped to max)
// the result sits in an output register, so a stalled result does not
// hold off the next input word; the sequencer waits only if that register
// is still full and stalled when a new result is ready
module loser_tree_kway_merge #(
    parameter int MAX_STREAMS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [3:0]  stream_index,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  winner_stream,
    output logic [63:0] winner_value,
    output logic        all_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import ltkm_pkg::*;

    localparam int IW = $clog2(MAX_STREAMS + 1);
    localparam int K_RESET = (16 > MAX_STREAMS) ? MAX_STREAMS : 16;

    logic [IW-1:0] k_reg, k_next;
    logic          out_valid_reg;
    res_t          out_reg;
    logic          busy;
    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          start;

    // streams_in_use, saturated into 2..max
    always_comb
    begin
        priority if (cfg_data < 5'd2)
        begin
            k_next = IW'(2);
        end
        else if (32'(cfg_data) > MAX_STREAMS)
        begin
            k_next = IW'(MAX_STREAMS);
        end
        else
        begin
            k_next = IW'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= IW'(K_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg <= k_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign start     = in_valid && !busy;
    assign res_ready = !out_valid_reg || !out_stall;

    ltkm_core #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind_t'(kind)),
        .stream_index (stream_index),
        .value_bits   (value_bits),
        .k            (k_reg),
        .res_ready    (res_ready),
        .busy         (busy),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign winner_stream = out_reg.stream;
    assign winner_value  = out_reg.value;
    assign all_done      = out_reg.done;

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg >= IW'(2)) && (32'(k_reg) <= MAX_STREAMS))
        else $error("stream count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_valid)
        else $error("pending output word overwritten");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_done) |-> (winner_value == PLUS_INF))
        else $error("done flag without plus infinity winner");
endmodule
